// ----- rtl/core/lfo_pkg.sv -----
// Shared types, constants and the quarter-wave sine generator for the LFO.
`timescale 1ns / 1ps

package lfo_pkg;

	// Default sizing
	localparam int BLOCK_SAMPLES_DEF   = 128;
	localparam int PHASE_BITS_DEF      = 32;
	localparam int SINE_TABLE_BITS_DEF = 8;

	// Configuration port
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 32;
	localparam int INC_W       = 32;
	localparam int SAMPLE_W    = 16;
	localparam int FRAC_W      = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_INC = 1'b1;

	typedef enum logic [1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_SQUARE   = 2'd1,
		WAVE_TRIANGLE = 2'd2,
		WAVE_SAWTOOTH = 2'd3
	} wave_t;

	localparam longint Q30_ONE = 64'sd1073741824;

	// Q30 product truncated toward zero
	function automatic longint q30_mul(input longint a, input longint b);
		return (a * b) / Q30_ONE;
	endfunction

	// Quarter-wave entry k of a 2^bits table: sin(pi/2 * k / 2^bits) in Q15, 0..32767.
	// Evaluated at elaboration only; odd Taylor series to x^9 in Q30.
	function automatic logic [14:0] sine_entry(input int k, input int bits);
		longint x;
		longint x2;
		longint s;
		longint r;
		x  = longint'(k) * (Q30_ONE >>> bits);
		x2 = q30_mul(x, x);
		s  = 64'sd172272;
		s  = -64'sd5026995 + q30_mul(s, x2);
		s  = 64'sd85569306 + q30_mul(s, x2);
		s  = -64'sd693598668 + q30_mul(s, x2);
		s  = 64'sd1686629713 + q30_mul(s, x2);
		s  = q30_mul(s, x);
		if (s < 0) begin
			s = 0;
		end
		r = (s * 64'sd32767 + (Q30_ONE / 2)) / Q30_ONE;
		if (r > 64'sd32767) begin
			r = 64'sd32767;
		end
		return 15'(r);
	endfunction

endpackage

// ----- rtl/core/lfo_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module lfo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/lfo_waveform_generator.sv -----
// Low-frequency oscillator top level: phase accumulator, waveform shaper, block counter.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid / in_ready / restart): every input beat asks for one
//   sample. restart = 1 zeroes the phase and the block position before that sample.
//   Output channel (out_valid / out_ready / sample / block_end): one beat per input
//   beat, in order. sample is signed Q1.15; block_end flags the last sample of each
//   block of BLOCK_SAMPLES samples.
//   Config port (cfg_we / cfg_index / cfg_data): index 0 selects the waveform
//   (sine, square, triangle, sawtooth), index 1 sets the phase increment and
//   zeroes the phase. Write only while no beat is in flight.
// Timing
//   An input beat passes the compute stage register, then the output register.
//   Throughput is one sample per cycle while out_ready holds: phase and block
//   position live in a one-entry state RAM with a registered read; the value written
//   at an edge is forwarded around the RAM so the next beat sees it immediately.
// Reset
//   Phase, block position, waveform and increment all read as zero after reset;
//   the state RAM is treated as zero until its first write.
// Backpressure
//   A stalled output holds its beat; one more beat waits in the compute stage,
//   after which in_ready drops until out_ready returns.

module lfo_waveform_generator #(
	parameter int BLOCK_SAMPLES   = lfo_pkg::BLOCK_SAMPLES_DEF,
	parameter int PHASE_BITS      = lfo_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = lfo_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// config
	input  logic                              cfg_we,
	input  logic [lfo_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [lfo_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              restart,
	// output channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [lfo_pkg::SAMPLE_W-1:0] sample,
	output logic                              block_end
);

	import lfo_pkg::*;

	localparam int POS_W  = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
	localparam int STATE_W = PHASE_BITS + POS_W;
	localparam int N      = 1 << SINE_TABLE_BITS;
	localparam int TOP_W  = SINE_TABLE_BITS + 2;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_SAMPLES - 1);

	// Config registers
	wave_t             waveform_q;
	logic [INC_W-1:0]  phase_inc_q;
	logic              cfg_inc_wr;

	assign cfg_inc_wr = cfg_we && (cfg_index == REG_PHASE_INC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q  <= WAVE_SINE;
			phase_inc_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WAVEFORM:  waveform_q  <= wave_t'(cfg_data[1:0]);
				REG_PHASE_INC: phase_inc_q <= cfg_data[INC_W-1:0];
				default: ;
			endcase
		end
	end

	// Compute stage and output register handshake
	logic valid_s1;
	logic restart_s1;
	logic adv;

	assign adv      = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			restart_s1 <= restart;
		end
	end

	// State RAM: {phase, block position}, read every cycle
	logic               wr_en;
	logic [STATE_W-1:0] wr_data;
	logic [STATE_W-1:0] rd_data;
	logic               init_q;     // RAM holds a written value
	logic               fwd_hit_q;  // last edge wrote, RAM read is one write behind
	logic [STATE_W-1:0] fwd_q;

	lfo_ram #(
		.WIDTH (STATE_W),
		.DEPTH (1)
	) u_state_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr ('0),
		.wdata (wr_data),
		.raddr ('0),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q    <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			init_q    <= init_q | wr_en;
			fwd_hit_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_q <= wr_data;
		end
	end

	logic [STATE_W-1:0]    cur_state;
	logic [PHASE_BITS-1:0] ph_cur;
	logic [POS_W-1:0]      pos_cur;
	logic [PHASE_BITS-1:0] ph_use;
	logic [POS_W-1:0]      pos_use;
	logic [PHASE_BITS-1:0] ph_next;
	logic [POS_W-1:0]      pos_next;
	logic                  last;

	always_comb begin
		if (!init_q) begin
			cur_state = '0;
		end else if (fwd_hit_q) begin
			cur_state = fwd_q;
		end else begin
			cur_state = rd_data;
		end
		ph_cur  = cur_state[STATE_W-1 -: PHASE_BITS];
		pos_cur = cur_state[POS_W-1:0];
		ph_use  = restart_s1 ? '0 : ph_cur;
		pos_use = restart_s1 ? '0 : pos_cur;
		last    = (pos_use >= LAST_POS);
		ph_next  = ph_use + PHASE_BITS'(phase_inc_q);
		pos_next = last ? '0 : pos_use + POS_W'(1);
	end

	// Increment write zeroes phase but keeps block position
	assign wr_en   = adv || cfg_inc_wr;
	assign wr_data = cfg_inc_wr ? {{PHASE_BITS{1'b0}}, pos_cur} : {ph_next, pos_next};

	// Quarter-wave sine table, built at elaboration
	logic [14:0] sine_rom [0:N];

	for (genvar k = 0; k <= N; k++) begin : g_sine
		assign sine_rom[k] = sine_entry(k, SINE_TABLE_BITS);
	end

	// Shaper
	logic [FRAC_W-1:0]          frac;
	logic [TOP_W-1:0]           top;
	logic [SINE_TABLE_BITS:0]   sin_idx;
	logic [14:0]                sin_mag;
	logic signed [17:0]         lin_v;
	logic signed [SAMPLE_W-1:0] shaped;

	always_comb begin
		frac    = ph_use[PHASE_BITS-1 -: FRAC_W];
		top     = ph_use[PHASE_BITS-1 -: TOP_W];
		sin_idx = top[TOP_W-2] ? ((SINE_TABLE_BITS+1)'(N) - {1'b0, top[SINE_TABLE_BITS-1:0]})
		                       : {1'b0, top[SINE_TABLE_BITS-1:0]};
		sin_mag = sine_rom[sin_idx];
		lin_v   = '0;
		case (waveform_q)
			WAVE_SINE: begin
				shaped = top[TOP_W-1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
			end
			WAVE_SQUARE: begin
				shaped = frac[FRAC_W-1] ? 16'sd32767 : -16'sd32768;
			end
			WAVE_TRIANGLE: begin
				// falling half 1-4p, rising half 4(p-1/2)-1
				lin_v = frac[FRAC_W-1] ? ($signed({1'b0, frac, 1'b0}) - 18'sd98304)
				                       : (18'sd32768 - $signed({1'b0, frac, 1'b0}));
				shaped = (lin_v > 18'sd32767) ? 16'sd32767 : SAMPLE_W'(lin_v);
			end
			WAVE_SAWTOOTH: begin
				lin_v  = 18'sd32768 - $signed({2'b00, frac});
				shaped = (lin_v > 18'sd32767) ? 16'sd32767 : SAMPLE_W'(lin_v);
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample    <= shaped;
			block_end <= last;
		end
	end

endmodule

// ----- rtl/core/lfo_checker.sv -----
// Port-level checker for the LFO, bound to the top level.
`timescale 1ns / 1ps

module lfo_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] sample,
	input logic        block_end
);

	// Stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(block_end))
		else $error("output beat changed while stalled");

	// A fresh output beat comes from an earlier input beat through the compute stage
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("output beat without matching input beat");

	// Input is only held off by a stalled output
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("in_ready low without output stall");

endmodule

bind lfo_waveform_generator lfo_checker u_lfo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.sample    (sample),
	.block_end (block_end)
);
